@@ rtl/kpsd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpsd_pkg
// Types, constants and the key table shared by the keypad scan blocks.
// ----------------------------------------------------------------------------
package kpsd_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_CFG     = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_COLS    = 4;

  localparam logic [4:0] MULTI_KEY   = 5'd31;
  localparam logic [9:0] BUZZ_MULTI  = 10'd600;
  localparam logic [9:0] BUZZ_SINGLE = 10'd30;
  localparam logic [2:0] EVAL_PHASE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER  = 3'd5;

  typedef logic [NUM_CFG-1:0][7:0] cfg_codes_t;

  typedef struct packed {
    logic [3:0] row_pins;
    logic       key_taken;
  } in_item_t;

  typedef struct packed {
    logic [1:0] next_column;
    logic       key_ready;
    logic [7:0] key_char;
    logic [9:0] buzz_min_ticks;
    logic [3:0] queue_fill;
  } out_item_t;

  typedef enum logic [1:0] {
    CL_NONE,
    CL_ONE,
    CL_MULTI
  } closure_e;

  // One classified scan round, passed from the front end to the back end.
  typedef struct packed {
    logic       eval;
    closure_e   kind;
    logic [4:0] code;
    logic [1:0] next_col;
    logic       key_taken;
  } round_t;

  function automatic logic [7:0] map_key(input logic [4:0] k, input cfg_codes_t codes);
    logic [7:0] ch;
    unique case (k)
      5'd1:    ch = 8'h31;
      5'd2:    ch = 8'h32;
      5'd3:    ch = 8'h33;
      5'd4:    ch = codes[CFG_ESCAPE];
      5'd5:    ch = 8'h34;
      5'd6:    ch = 8'h35;
      5'd7:    ch = 8'h36;
      5'd8:    ch = codes[CFG_UP];
      5'd9:    ch = 8'h37;
      5'd10:   ch = 8'h38;
      5'd11:   ch = 8'h39;
      5'd12:   ch = codes[CFG_DOWN];
      5'd13:   ch = codes[CFG_LEFT];
      5'd14:   ch = 8'h30;
      5'd15:   ch = codes[CFG_RIGHT];
      5'd16:   ch = codes[CFG_ENTER];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/kpsd_front.sv @@
// ----------------------------------------------------------------------------
// kpsd_front
// Tracks the scan phase and classifies the row closures of each round.
// ----------------------------------------------------------------------------
module kpsd_front
  import kpsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output round_t   round_o
);

  logic [2:0] phase_q, phase_d;
  logic [3:0] closed;
  logic [1:0] row_sel;
  logic       is_eval;

  assign is_eval = (phase_q == EVAL_PHASE);
  assign closed  = ~item_i.row_pins;

  always_comb begin
    row_sel = 2'd0;
    for (int r = NUM_COLS - 1; r >= 0; r--) begin
      if (closed[r]) row_sel = 2'(r);
    end
  end

  always_comb begin
    round_o.eval      = is_eval;
    round_o.key_taken = item_i.key_taken;
    round_o.code      = {1'b0, row_sel, phase_q[1:0]} + 5'd1;
    round_o.next_col  = (phase_q < 3'd3) ? phase_q[1:0] + 2'd1 : 2'd0;
    if (is_eval || closed == 4'd0) begin
      round_o.kind = CL_NONE;
    end else if ((closed & (closed - 4'd1)) == 4'd0) begin
      round_o.kind = CL_ONE;
    end else begin
      round_o.kind = CL_MULTI;
    end
  end

  assign phase_d = is_eval ? 3'd0 : phase_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 3'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/kpsd_link.sv @@
// ----------------------------------------------------------------------------
// kpsd_link
// Two-entry queue carrying classified rounds from front end to back end.
// ----------------------------------------------------------------------------
module kpsd_link
  import kpsd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  round_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   avail_o,
  output round_t data_o
);

  round_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  assign cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

@@ rtl/kpsd_back.sv @@
// ----------------------------------------------------------------------------
// kpsd_back
// Scan accumulation, two-scan debounce, key queue and character hold.
// ----------------------------------------------------------------------------
module kpsd_back
  import kpsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 avail_i,
  input  round_t               round_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  cfg_codes_t        codes_q;
  logic [4:0]        cur_q, cur_d, prev_q, prev_d, older_q, older_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d, cnt_push;
  logic [7:0]        held_q, held_d, held_clr;
  logic [4:0]        kq_q [QUEUE_DEPTH];
  logic [4:0]        kq_push [QUEUE_DEPTH];
  logic [4:0]        kq_d [QUEUE_DEPTH];
  logic              out_valid_q;
  out_item_t         out_q, out_d;
  logic              fire, press, push, pop;
  logic [9:0]        buzz;

  assign fire  = avail_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  always_comb begin
    held_clr = round_i.key_taken ? 8'd0 : held_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    older_d  = older_q;
    buzz     = 10'd0;
    push     = 1'b0;
    press    = 1'b0;
    if (!round_i.eval) begin
      case (round_i.kind)
        CL_ONE:   cur_d = (cur_q != 5'd0) ? MULTI_KEY : round_i.code;
        CL_MULTI: cur_d = MULTI_KEY;
        default:  cur_d = cur_q;
      endcase
    end else begin
      press = (cur_q != 5'd0) && (prev_q == cur_q) && (older_q != cur_q);
      if (press) begin
        if (cur_q == MULTI_KEY) begin
          buzz = BUZZ_MULTI;
        end else if (cnt_q < QCNT_W'(QUEUE_DEPTH)) begin
          push = 1'b1;
          buzz = BUZZ_SINGLE;
        end
      end
      older_d = prev_q;
      prev_d  = cur_q;
      cur_d   = 5'd0;
    end

    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      kq_push[i] = (push && cnt_q == QCNT_W'(i)) ? cur_q : kq_q[i];
    end
    cnt_push = cnt_q + QCNT_W'(push);
    pop      = (held_clr == 8'd0) && (cnt_push != '0);
    held_d   = pop ? map_key(kq_push[0], codes_q) : held_clr;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!pop) begin
        kq_d[i] = kq_push[i];
      end else if (i + 1 < QUEUE_DEPTH) begin
        kq_d[i] = kq_push[i + 1];
      end else begin
        kq_d[i] = 5'd0;
      end
    end
    cnt_d = cnt_push - QCNT_W'(pop);

    out_d.next_column    = round_i.next_col;
    out_d.key_ready      = (held_d != 8'd0);
    out_d.key_char       = held_d;
    out_d.buzz_min_ticks = buzz;
    out_d.queue_fill     = 4'(32'(cnt_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q[CFG_ESCAPE] <= 8'd27;
      codes_q[CFG_UP]     <= 8'd128;
      codes_q[CFG_DOWN]   <= 8'd129;
      codes_q[CFG_LEFT]   <= 8'd130;
      codes_q[CFG_RIGHT]  <= 8'd131;
      codes_q[CFG_ENTER]  <= 8'd13;
      cur_q       <= 5'd0;
      prev_q      <= 5'd0;
      older_q     <= 5'd0;
      cnt_q       <= '0;
      held_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i < CFG_IDX_W'(NUM_CFG)) begin
        codes_q[cfg_idx_i] <= cfg_data_i;
      end
      if (fire) begin
        cur_q   <= cur_d;
        prev_q  <= prev_d;
        older_q <= older_d;
        cnt_q   <= cnt_d;
        held_q  <= held_d;
      end
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
      kq_q  <= kq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("key queue count above depth");

  a_buzz_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.buzz_min_ticks != 10'd0) |-> out_q.next_column == 2'd0)
    else $error("buzz requested outside an evaluation round");

  a_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !round_i.eval) |=> cnt_q <= $past(cnt_q))
    else $error("key queue grew in a scan round");

  a_ready_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.key_ready == (out_q.key_char != 8'd0)))
    else $error("key_ready disagrees with key_char");

endmodule

@@ rtl/matrix_keypad_scan_debounce_queue.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_scan_debounce_queue
// 4x4 keypad scanner with two-scan debounce and a queue of pressed keys.
// ----------------------------------------------------------------------------
// Each input item is one scan round: the active-low row levels of the column
// driven now and a key_taken flag that clears the held character. Four scan
// rounds are followed by one evaluation round; every round yields exactly one
// result item with the column to drive next, the held character, the buzz
// request and the fill of the key queue.
// Input and output use valid/stall. An accepted item is written into the
// link queue and its result is registered in the back end; one item per
// cycle is sustained while out_stall_i is low. A two-entry queue sits
// between the classifying front end and the back end, so a stalled receiver
// backs up into it; in_stall_o rises when it is full. Reset clears all scan
// state, empties the key queue, drops the held character and loads the
// default key codes. Code registers must be written by the user through
// cfg_we_i / cfg_idx_i / cfg_data_i only while idle; the block does not check.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_queue
  import kpsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  logic   link_full, link_avail, link_pop, in_accept;
  round_t front_round, back_round;

  assign in_stall_o = link_full;
  assign in_accept  = in_valid_i && !link_full;

  kpsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .round_o  (front_round)
  );

  kpsd_link u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .data_i  (front_round),
    .full_o  (link_full),
    .pop_i   (link_pop),
    .avail_o (link_avail),
    .data_o  (back_round)
  );

  kpsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .avail_i     (link_avail),
    .round_i     (back_round),
    .pop_o       (link_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
